// ===== sv/assert_macros.svh =====
// Assertion macros used by perlin_noise_2d_fractal.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pnf_pkg.sv =====
// Package for the fractal noise block: fixed-point constants, register
// indexes, divider status type and the gradient select function.
package pnf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int OUT_W     = 16;
    localparam int AMP_W     = 17;
    localparam int AMP_ONE   = 65536;
    localparam int PERS_W    = 16;
    localparam int OCTCFG_W  = 4;
    localparam int MUL_W     = FRAC_BITS + 6;
    localparam int G_W       = FRAC_BITS + 3;
    localparam int E_W       = FRAC_BITS + 4;
    localparam int PW        = FRAC_BITS + 5;
    localparam int FADE_C6   = 6;
    localparam int FADE_C10  = 10;
    localparam int FADE_C15  = 15;
    localparam int GRAD_SEL_W = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

    localparam logic [GRAD_SEL_W-1:0] GRAD_X     = 3'd0;
    localparam logic [GRAD_SEL_W-1:0] GRAD_XPY   = 3'd1;
    localparam logic [GRAD_SEL_W-1:0] GRAD_Y     = 3'd2;
    localparam logic [GRAD_SEL_W-1:0] GRAD_YMX   = 3'd3;
    localparam logic [GRAD_SEL_W-1:0] GRAD_NX    = 3'd4;
    localparam logic [GRAD_SEL_W-1:0] GRAD_NXMY  = 3'd5;
    localparam logic [GRAD_SEL_W-1:0] GRAD_NY    = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic signed [G_W-1:0] grad(
        input logic [GRAD_SEL_W-1:0] h,
        input logic signed [G_W-1:0] x,
        input logic signed [G_W-1:0] y
    );
        logic signed [G_W-1:0] r;
        case (h)
            GRAD_X:    r = x;
            GRAD_XPY:  r = x + y;
            GRAD_Y:    r = y;
            GRAD_YMX:  r = y - x;
            GRAD_NX:   r = -x;
            GRAD_NXMY: r = -x - y;
            GRAD_NY:   r = -y;
            default:   r = x - y;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pnf_hash_ram.sv =====
// Hash table storage: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
module pnf_hash_ram #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  logic [7:0]                     wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic [7:0]                     rdata
);

    logic [7:0] hash_mem [TABLE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hash_mem[waddr] <= wdata;
        end
        rdata_reg <= hash_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pnf_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to OUT_W bits.
// Computes floor(num / (2 * den)); depends on pnf_pkg.
module pnf_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num,
    input  logic [DEN_W-1:0]          den,
    output pnf_pkg::div_status_t      status,
    output logic [pnf_pkg::OUT_W-1:0] quot
);
    import pnf_pkg::*;

    localparam int DSH_W = DEN_W + OUT_W + 1;
    localparam int RW    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int STEPS = OUT_W + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    dsh_reg;
    logic [OUT_W:0]   q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(num);
            dsh_reg <= RW'({den, 1'b0}) << OUT_W;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[OUT_W-1:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[OUT_W-1:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot = q_reg[OUT_W] ? {OUT_W{1'b1}} : q_reg[OUT_W-1:0];

endmodule

// ===== sv/perlin_noise_2d_fractal.sv =====
// 2D fractal Perlin noise. A table load word is done in its accept cycle. An evaluate
// word runs states S_A to S_M once per octave on one shared 22x22 multiplier and table
// port, starts the divider in S_DIV0, waits in S_DIVW for the bit-serial divider and
// loads the output register in S_OUT; the divider is skipped when the sum is not positive.
// No new word is taken until the last evaluate is done; in_ready is low while busy or stalled.
// Reset: octave_count 1, persistence 32768, output empty; table undefined.
module perlin_noise_2d_fractal #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [7:0]                     table_index,
    input  logic [7:0]                     table_value,
    input  logic signed [31:0]             coord_x,
    input  logic signed [31:0]             coord_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pnf_pkg::OUT_W-1:0]      noise_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pnf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pnf_pkg::*;

`include "assert_macros.svh"

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = FRAC_BITS + AW;
    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int TOT_W = FRAC_BITS + 20 + $clog2(MAX_OCTAVES);
    localparam int WS_W  = 17 + $clog2(MAX_OCTAVES);

    typedef enum logic [4:0] {
        S_IDLE, S_A, S_B, S_C, S_D, S_E, S_F, S_G, S_H, S_I, S_J, S_K, S_L, S_M,
        S_DIV0, S_DIVW, S_OUT
    } state_t;

    state_t                  state_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        noise_reg;
    logic [OUT_W-1:0]        result_reg;
    logic [OCTCFG_W-1:0]     octave_count_reg;
    logic [PERS_W-1:0]       pers_reg;

    logic [CW-1:0]           x_reg;
    logic [CW-1:0]           y_reg;
    logic [OCT_W-1:0]        oct_reg;
    logic [OCT_W-1:0]        n_reg;
    logic [OCT_W-1:0]        n_clamp;
    logic [7:0]              hx0_reg, hx1_reg, h00_reg, h10_reg, h01_reg, h11_reg;
    logic [FRAC_BITS-1:0]    t2x_reg, t2y_reg, t3x_reg, t3y_reg;
    logic [FRAC_BITS:0]      u_reg, v_reg;
    logic signed [E_W-1:0]   e0_reg, e1_reg, s_reg;
    logic [AMP_W-1:0]        amp_reg, ampn_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [WS_W-1:0]         wsum_reg;
    logic signed [2*MUL_W-1:0] prod_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rdata;
    logic [FRAC_BITS-1:0]    lx, ly;
    logic [AW-1:0]           x0, x1, y0, y1;
    logic [PW-1:0]           px, py;
    logic signed [G_W-1:0]   fx0, fx1, fy0, fy1;
    logic signed [G_W-1:0]   g0, g1, g2, g3;
    logic signed [E_W-1:0]   gd01, gd23, ed, lerp_q;
    logic                    accept;
    logic                    div_start;
    div_status_t             div_stat;
    logic [OUT_W-1:0]        div_quot;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign noise_value = noise_reg;

    assign lx = x_reg[FRAC_BITS-1:0];
    assign ly = y_reg[FRAC_BITS-1:0];
    assign x0 = x_reg[CW-1:FRAC_BITS];
    assign y0 = y_reg[CW-1:FRAC_BITS];
    assign x1 = x0 + AW'(1);
    assign y1 = y0 + AW'(1);

    assign px = PW'(t2x_reg) * PW'(FADE_C6) + PW'(FADE_C10) * PW'(ONE)
              - PW'(FADE_C15) * PW'(lx);
    assign py = PW'(t2y_reg) * PW'(FADE_C6) + PW'(FADE_C10) * PW'(ONE)
              - PW'(FADE_C15) * PW'(ly);

    assign fx0 = $signed(G_W'(lx));
    assign fy0 = $signed(G_W'(ly));
    assign fx1 = fx0 - G_W'(ONE);
    assign fy1 = fy0 - G_W'(ONE);
    assign g0 = grad(h00_reg[GRAD_SEL_W-1:0], fx0, fy0);
    assign g1 = grad(h10_reg[GRAD_SEL_W-1:0], fx1, fy0);
    assign g2 = grad(h01_reg[GRAD_SEL_W-1:0], fx0, fy1);
    assign g3 = grad(h11_reg[GRAD_SEL_W-1:0], fx1, fy1);
    assign gd01 = E_W'(g1) - E_W'(g0);
    assign gd23 = E_W'(g3) - E_W'(g2);
    assign ed = e1_reg - e0_reg;
    assign lerp_q = E_W'(prod_reg >>> FRAC_BITS);

    always_comb
    begin
        if (octave_count_reg == '0)
        begin
            n_clamp = OCT_W'(1);
        end
        else if (int'(octave_count_reg) > MAX_OCTAVES)
        begin
            n_clamp = OCT_W'(MAX_OCTAVES);
        end
        else
        begin
            n_clamp = OCT_W'(octave_count_reg);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_B:     rd_addr = x1;
            S_C:     rd_addr = AW'(hx0_reg) + y0;
            S_D:     rd_addr = AW'(hx1_reg) + y0;
            S_E:     rd_addr = AW'(hx0_reg) + y1;
            S_F:     rd_addr = AW'(hx1_reg) + y1;
            default: rd_addr = x0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_A:     begin mul_a = MUL_W'(lx);      mul_b = MUL_W'(lx);       end
            S_B:     begin mul_a = MUL_W'(ly);      mul_b = MUL_W'(ly);       end
            S_C:     begin mul_a = MUL_W'(t2x_reg); mul_b = MUL_W'(lx);       end
            S_D:     begin mul_a = MUL_W'(t2y_reg); mul_b = MUL_W'(ly);       end
            S_E:     begin mul_a = MUL_W'(t3x_reg); mul_b = MUL_W'(px);       end
            S_F:     begin mul_a = MUL_W'(t3y_reg); mul_b = MUL_W'(py);       end
            S_G:     begin mul_a = MUL_W'(gd01);    mul_b = MUL_W'(u_reg);    end
            S_H:     begin mul_a = MUL_W'(gd23);    mul_b = MUL_W'(u_reg);    end
            S_J:     begin mul_a = MUL_W'(ed);      mul_b = MUL_W'(v_reg);    end
            S_K:     begin mul_a = MUL_W'(amp_reg); mul_b = MUL_W'(pers_reg); end
            S_L:     begin mul_a = MUL_W'(s_reg);   mul_b = MUL_W'(amp_reg);  end
            default: begin mul_a = '0;              mul_b = '0;               end
        endcase
    end

    assign div_start = (state_reg == S_DIV0) && !total_reg[TOT_W-1] && (total_reg != '0);

    pnf_hash_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && !mode),
        .waddr (AW'(table_index)),
        .wdata (table_value),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    pnf_div #(
        .NUM_W(TOT_W),
        .DEN_W(WS_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (TOT_W'(total_reg)),
        .den    (wsum_reg),
        .status (div_stat),
        .quot   (div_quot)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept && mode)
        begin
            x_reg     <= coord_x[CW-1:0];
            y_reg     <= coord_y[CW-1:0];
            total_reg <= '0;
            wsum_reg  <= '0;
            amp_reg   <= AMP_W'(AMP_ONE);
            oct_reg   <= '0;
            n_reg     <= n_clamp;
        end
        case (state_reg)
            S_B:
            begin
                hx0_reg <= rdata;
                t2x_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            end
            S_C:
            begin
                hx1_reg <= rdata;
                t2y_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            end
            S_D:
            begin
                h00_reg <= rdata;
                t3x_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            end
            S_E:
            begin
                h10_reg <= rdata;
                t3y_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            end
            S_F:
            begin
                h01_reg <= rdata;
                u_reg   <= prod_reg[2*FRAC_BITS:FRAC_BITS];
            end
            S_G:
            begin
                h11_reg <= rdata;
                v_reg   <= prod_reg[2*FRAC_BITS:FRAC_BITS];
            end
            S_H: e0_reg <= E_W'(g0) + lerp_q;
            S_I: e1_reg <= E_W'(g2) + lerp_q;
            S_K: s_reg  <= e0_reg + lerp_q + E_W'(ONE);
            S_L: ampn_reg <= prod_reg[2*FRAC_BITS:FRAC_BITS];
            S_M:
            begin
                total_reg <= total_reg + TOT_W'(prod_reg);
                wsum_reg  <= wsum_reg + WS_W'(amp_reg);
                amp_reg   <= ampn_reg;
                x_reg     <= x_reg << 1;
                y_reg     <= y_reg << 1;
                oct_reg   <= oct_reg + OCT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            noise_reg        <= '0;
            result_reg       <= '0;
            octave_count_reg <= OCTCFG_W'(1);
            pers_reg         <= PERS_W'(32768);
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[OCTCFG_W-1:0];
                    REG_PERSISTENCE:  pers_reg <= cfg_data[PERS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && mode)
                    begin
                        state_reg <= S_A;
                    end
                end
                S_A: state_reg <= S_B;
                S_B: state_reg <= S_C;
                S_C: state_reg <= S_D;
                S_D: state_reg <= S_E;
                S_E: state_reg <= S_F;
                S_F: state_reg <= S_G;
                S_G: state_reg <= S_H;
                S_H: state_reg <= S_I;
                S_I: state_reg <= S_J;
                S_J: state_reg <= S_K;
                S_K: state_reg <= S_L;
                S_L: state_reg <= S_M;
                S_M:
                begin
                    if ((oct_reg + OCT_W'(1)) == n_reg)
                    begin
                        state_reg <= S_DIV0;
                    end
                    else
                    begin
                        state_reg <= S_A;
                    end
                end
                S_DIV0:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIVW;
                    end
                    else
                    begin
                        result_reg <= '0;
                        state_reg  <= S_OUT;
                    end
                end
                S_DIVW:
                begin
                    if (div_stat.done)
                    begin
                        result_reg <= div_quot;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        noise_reg     <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_div_busy_state, clk, rst_n, div_stat.busy, state_reg == S_DIVW)
    `ASSERT_IMPLY(a_wsum_nonzero, clk, rst_n, state_reg == S_DIVW, wsum_reg != '0)
    `ASSERT_IMPLY(a_octave_bound, clk, rst_n, state_reg == S_A, oct_reg < n_reg)
    `ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_OUT) && (!out_valid_reg || out_ready), out_valid_reg)

endmodule
